// ----- rtl/kcs_pkg.sv -----
// Package for the keypad clock-setting controller.
// Holds key codes, set kinds, the display width, the pipeline snapshot type
// and the small BCD helper. No dependencies.
`timescale 1ns / 1ps

package kcs_pkg;

    // Number of BCD digits driven on the display word (6 to 8)
    localparam int DISPLAY_DIGITS = 8;
    // Decimal digits held by the entry accumulator
    localparam int ENTRY_DIGITS   = 9;
    localparam int ENTRY_W        = 30;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

    // Keypad codes (column*4 + row) of the non-digit keys and of digit zero
    localparam logic [3:0] KEY_SET_HOURS   = 4'd3;
    localparam logic [3:0] KEY_SET_MINUTES = 4'd7;
    localparam logic [3:0] KEY_SET_SECONDS = 4'd11;
    localparam logic [3:0] KEY_PROG_ENTER  = 4'd12;
    localparam logic [3:0] KEY_ZERO        = 4'd13;
    localparam logic [3:0] KEY_PROG_LEAVE  = 4'd14;
    localparam logic [3:0] KEY_CLEAR       = 4'd15;

    typedef enum logic [1:0] {
        SET_NONE    = 2'd0,
        SET_HOURS   = 2'd1,
        SET_MINUTES = 2'd2,
        SET_SECONDS = 2'd3
    } t_set_kind;

    // State after one item, handed from the update stage to the output stage
    typedef struct packed {
        logic [ENTRY_DIGITS-1:0][3:0] entry_bcd;
        logic                         prog_mode;
        logic [4:0]                   hours;
        logic [5:0]                   minutes;
        logic [5:0]                   seconds;
        t_set_kind                    set_kind;
        logic [5:0]                   set_value;
        logic                         key_accepted;
    } t_kcs_snap;

    // Two BCD digits of a 6-bit value; tens by reciprocal multiply (exact below 1029)
    function automatic logic [7:0] bin6_to_bcd(input logic [5:0] v);
        logic [13:0] prod;
        logic [2:0]  tens;
        logic [5:0]  ones;
        prod = 14'(v) * 14'd205;
        tens = prod[13:11];
        ones = v - 6'(tens) * 6'd10;
        return {1'b0, tens, ones[3:0]};
    endfunction

endpackage

// ----- rtl/kcs_in_if.sv -----
// Input channel of the keypad clock-setting controller: time samples and key items.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

interface kcs_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  hours_in;
    logic [5:0]  minutes_in;
    logic [5:0]  seconds_in;
    logic [3:0]  key_code;
    logic [31:0] tick_ms;

    modport source (output valid, command, hours_in, minutes_in, seconds_in, key_code,
                    tick_ms, input ready);
    modport sink   (input valid, command, hours_in, minutes_in, seconds_in, key_code,
                    tick_ms, output ready);
endinterface

// ----- rtl/kcs_out_if.sv -----
// Result channel of the keypad clock-setting controller: display word and status.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

interface kcs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] display_bcd;
    logic [29:0] entry_value;
    logic        program_mode_out;
    logic [1:0]  set_kind;
    logic [5:0]  set_value;
    logic        key_accepted;

    modport source (output valid, display_bcd, entry_value, program_mode_out, set_kind,
                    set_value, key_accepted, input ready);
    modport sink   (input valid, display_bcd, entry_value, program_mode_out, set_kind,
                    set_value, key_accepted, output ready);
endinterface

// ----- rtl/kcs_core.sv -----
// Update stage: debounce, key decode, BCD entry accumulator and held time.
// Depends on kcs_pkg and kcs_in_if.
`timescale 1ns / 1ps

module kcs_core import kcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    kcs_in_if.sink      i_key_ch,
    input  logic        i_snap_ready,
    output logic        o_snap_valid,
    output t_kcs_snap   o_snap
);

    logic [15:0]                  r_debounce;
    logic [ENTRY_DIGITS-1:0][3:0] r_entry, n_entry;
    logic                         r_mode, n_mode;
    logic [31:0]                  r_last_tick, n_last_tick;
    logic [4:0]                   r_hours, n_hours;
    logic [5:0]                   r_minutes, n_minutes;
    logic [5:0]                   r_seconds, n_seconds;
    t_set_kind                    r_kind, n_kind;
    logic [5:0]                   r_sval, n_sval;
    logic                         r_acc, n_acc;
    logic                         r_valid;

    logic        in_fire;
    logic        deb_ok;
    logic [31:0] tick_gap;
    logic [1:0]  key_col, key_row;
    logic        is_digit;
    logic [3:0]  digit;
    logic        upper_zero, le23, le59;
    logic [5:0]  entry_low;

    // Take an item whenever the snapshot is empty or moving on
    assign i_key_ch.ready = !r_valid || i_snap_ready;
    assign in_fire        = i_key_ch.valid && i_key_ch.ready;

    // Debounce on the wrapping distance since the last accepted key
    assign tick_gap = i_key_ch.tick_ms - r_last_tick;
    assign deb_ok   = tick_gap >= {16'd0, r_debounce};

    // Decode digit keys: columns 0..2 rows 0..2, plus zero in column 3
    assign key_col  = i_key_ch.key_code[3:2];
    assign key_row  = i_key_ch.key_code[1:0];
    assign is_digit = (key_col != 2'd3 && key_row != 2'd3) || i_key_ch.key_code == KEY_ZERO;
    assign digit    = (i_key_ch.key_code == KEY_ZERO) ? 4'd0
                    : 4'(key_col) * 4'd3 + 4'(key_row) + 4'd1;

    // Range checks on the BCD entry
    assign upper_zero = (r_entry[ENTRY_DIGITS-1:2] == '0);
    assign le23 = upper_zero && (r_entry[1] < 4'd2 || (r_entry[1] == 4'd2 && r_entry[0] <= 4'd3));
    assign le59 = upper_zero && (r_entry[1] <= 4'd5);
    assign entry_low = 6'(r_entry[1]) * 6'd10 + 6'(r_entry[0]);

    // Work out the state after the presented item
    always_comb begin
        n_entry     = r_entry;
        n_mode      = r_mode;
        n_last_tick = r_last_tick;
        n_hours     = r_hours;
        n_minutes   = r_minutes;
        n_seconds   = r_seconds;
        n_kind      = SET_NONE;
        n_sval      = 6'd0;
        n_acc       = 1'b0;
        if (!i_key_ch.command) begin
            n_hours   = i_key_ch.hours_in;
            n_minutes = i_key_ch.minutes_in;
            n_seconds = i_key_ch.seconds_in;
        end else if (deb_ok) begin
            n_acc       = 1'b1;
            n_last_tick = i_key_ch.tick_ms;
            if (is_digit) begin
                n_entry = {r_entry[ENTRY_DIGITS-2:0], digit};
            end else begin
                case (i_key_ch.key_code)
                    KEY_SET_HOURS: begin
                        if (le23) begin
                            n_kind  = SET_HOURS;
                            n_sval  = entry_low;
                            n_hours = entry_low[4:0];
                            n_entry = '0;
                        end
                    end
                    KEY_SET_MINUTES: begin
                        if (le59) begin
                            n_kind    = SET_MINUTES;
                            n_sval    = entry_low;
                            n_minutes = entry_low;
                            n_entry   = '0;
                        end
                    end
                    KEY_SET_SECONDS: begin
                        if (le59) begin
                            n_kind    = SET_SECONDS;
                            n_sval    = entry_low;
                            n_seconds = entry_low;
                            n_entry   = '0;
                        end
                    end
                    KEY_PROG_ENTER: begin
                        n_mode = 1'b1;
                    end
                    KEY_PROG_LEAVE: begin
                        n_mode  = 1'b0;
                        n_entry = '0;
                    end
                    default: begin
                        n_entry = '0;
                    end
                endcase
            end
        end
    end

    // Hold the state; it doubles as the snapshot of the last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RESET;
            r_entry     <= '0;
            r_mode      <= 1'b0;
            r_last_tick <= '0;
            r_hours     <= '0;
            r_minutes   <= '0;
            r_seconds   <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_entry     <= n_entry;
                r_mode      <= n_mode;
                r_last_tick <= n_last_tick;
                r_hours     <= n_hours;
                r_minutes   <= n_minutes;
                r_seconds   <= n_seconds;
                r_valid     <= 1'b1;
            end else if (i_snap_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Per-item flags travel alongside the state
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= n_kind;
            r_sval <= n_sval;
            r_acc  <= n_acc;
        end
    end

    assign o_snap_valid = r_valid;
    always_comb begin
        o_snap.entry_bcd    = r_entry;
        o_snap.prog_mode    = r_mode;
        o_snap.hours        = r_hours;
        o_snap.minutes      = r_minutes;
        o_snap.seconds      = r_seconds;
        o_snap.set_kind     = r_kind;
        o_snap.set_value    = r_sval;
        o_snap.key_accepted = r_acc;
    end

    // A time sample never touches the entry or the mode
    a_sample_keeps_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_key_ch.command) |=> (r_entry == $past(r_entry) && r_mode == $past(r_mode)))
        else $error("time sample changed entry or mode");

    // A bounced key leaves the whole key state alone
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_key_ch.command && !deb_ok)
        |=> (r_entry == $past(r_entry) && r_last_tick == $past(r_last_tick) && !r_acc))
        else $error("rejected key changed state");

    // An accepted key restarts the debounce window at its own stamp
    a_accept_stamps_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_key_ch.command && deb_ok) |=> (r_last_tick == $past(i_key_ch.tick_ms)))
        else $error("accepted key did not record its tick");

    // A successful set always leaves an empty entry
    a_set_clears_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != SET_NONE) |-> (r_entry == '0))
        else $error("set left entry non-zero");

endmodule

// ----- rtl/kcs_out.sv -----
// Output stage: builds the BCD display word and the binary entry, then registers the item.
// Depends on kcs_pkg and kcs_out_if.
`timescale 1ns / 1ps

module kcs_out import kcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_snap_valid,
    input  t_kcs_snap   i_snap,
    output logic        o_snap_ready,
    kcs_out_if.source   o_disp_ch
);

    logic                  r_valid;
    logic [31:0]           r_display;
    logic [ENTRY_W-1:0]    r_entry_value;
    logic                  r_mode;
    t_set_kind             r_kind;
    logic [5:0]            r_sval;
    logic                  r_acc;

    logic [7:0]            sec_bcd, min_bcd, hr_bcd;
    logic [7:0][3:0]       clock_digits;
    logic [7:0][3:0]       disp_digits;
    logic [9:0]            grp0, grp1, grp2;
    logic [ENTRY_W-1:0]    entry_bin;
    logic                  load;

    assign o_snap_ready = !r_valid || o_disp_ch.ready;
    assign load         = i_snap_valid && o_snap_ready;

    // Clock mode digits: hh0mm0ss with the gaps left at zero
    assign sec_bcd = bin6_to_bcd(i_snap.seconds);
    assign min_bcd = bin6_to_bcd(i_snap.minutes);
    assign hr_bcd  = bin6_to_bcd({1'b0, i_snap.hours});
    assign clock_digits = {hr_bcd, 4'd0, min_bcd, 4'd0, sec_bcd};

    // Select the shown value and drop digits beyond the display width
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (i >= DISPLAY_DIGITS) begin
                disp_digits[i] = 4'd0;
            end else if (i_snap.prog_mode) begin
                disp_digits[i] = i_snap.entry_bcd[i];
            end else begin
                disp_digits[i] = clock_digits[i];
            end
        end
    end

    // Entry back to binary, three digits at a time
    assign grp0 = 10'(i_snap.entry_bcd[2]) * 10'd100 + 10'(i_snap.entry_bcd[1]) * 10'd10
                + 10'(i_snap.entry_bcd[0]);
    assign grp1 = 10'(i_snap.entry_bcd[5]) * 10'd100 + 10'(i_snap.entry_bcd[4]) * 10'd10
                + 10'(i_snap.entry_bcd[3]);
    assign grp2 = 10'(i_snap.entry_bcd[8]) * 10'd100 + 10'(i_snap.entry_bcd[7]) * 10'd10
                + 10'(i_snap.entry_bcd[6]);
    assign entry_bin = ENTRY_W'(grp2) * ENTRY_W'(1000000) + ENTRY_W'(grp1) * ENTRY_W'(1000)
                     + ENTRY_W'(grp0);

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_disp_ch.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_display     <= disp_digits;
            r_entry_value <= entry_bin;
            r_mode        <= i_snap.prog_mode;
            r_kind        <= i_snap.set_kind;
            r_sval        <= i_snap.set_value;
            r_acc         <= i_snap.key_accepted;
        end
    end

    assign o_disp_ch.valid            = r_valid;
    assign o_disp_ch.display_bcd      = r_display;
    assign o_disp_ch.entry_value      = r_entry_value;
    assign o_disp_ch.program_mode_out = r_mode;
    assign o_disp_ch.set_kind         = r_kind;
    assign o_disp_ch.set_value        = r_sval;
    assign o_disp_ch.key_accepted     = r_acc;

endmodule

// ----- rtl/keypad_clock_setting_controller.sv -----
// Keypad clock-setting controller, top level.
// Channels: i_key_ch (sink) takes time samples (command 0) and key items
// (command 1) with a millisecond stamp; o_disp_ch (source) gives one result
// item per input item: the BCD display word, the entry, the mode and any
// hours/minutes/seconds set request. i_cfg_we/i_cfg_wdata write debounce_ms.
// An accepted item is registered in the update stage, then in the output stage.
// Throughput: one item per cycle while o_disp_ch.ready is high; the entry is
// kept in BCD so that the state update (debounce compare, digit shift, range
// check) works on BCD digits; conversion back to binary sits in the output stage.
// Reset (synchronous, active low): entry, mode, held time and last key stamp
// clear, debounce returns to 50 ms, both stages empty. Keys stamped below
// debounce_ms after reset are rejected.
// Stall: while o_disp_ch.ready is low the result holds, one more item is taken
// into the update stage, and i_key_ch.ready then drops until the result moves.
// Depends on kcs_pkg, kcs_in_if, kcs_out_if, kcs_core and kcs_out.
`timescale 1ns / 1ps

module keypad_clock_setting_controller import kcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    kcs_in_if.sink      i_key_ch,
    kcs_out_if.source   o_disp_ch
);

    logic      snap_valid;
    logic      snap_ready;
    t_kcs_snap snap;

    // Update stage
    kcs_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_key_ch     (i_key_ch),
        .i_snap_ready (snap_ready),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    // Output stage
    kcs_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_ready (snap_ready),
        .o_disp_ch    (o_disp_ch)
    );

endmodule

// ----- dv/testbench.sv -----
// Testbench for the keypad clock-setting controller: directed and random key and
// time-sample traffic, checked item by item against a behavioural predictor.
// Depends on kcs_pkg, kcs_in_if, kcs_out_if and keypad_clock_setting_controller.
`timescale 1ns / 1ps

module testbench;
    import kcs_pkg::*;

    // Expected content of one result item
    typedef struct packed {
        logic [31:0] display;
        logic [29:0] entry;
        logic        prog;
        t_set_kind   kind;
        logic [5:0]  sval;
        logic        accepted;
    } t_disp_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    kcs_in_if  key_ch ();
    kcs_out_if disp_ch ();

    keypad_clock_setting_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_key_ch    (key_ch),
        .o_disp_ch   (disp_ch)
    );

    always #2 i_clk = ~i_clk;

    // Predicted controller state
    logic [29:0] held_entry;
    logic        held_prog;
    logic [31:0] held_last_tick;
    logic [4:0]  held_hours;
    logic [5:0]  held_minutes;
    logic [5:0]  held_seconds;
    logic [15:0] held_debounce;

    t_disp_result display_due[$];

    logic        tx_idle;
    logic        rx_idle;
    int unsigned stall_left;
    int unsigned hold_left;
    logic [31:0] tick_now;
    int unsigned items_sent;
    int unsigned mismatches;
    int unsigned keys_taken;
    int unsigned sets_made;
    int unsigned debounce_writes;

    // Eight-digit BCD word of a value, lowest digit in the low nibble
    function automatic logic [31:0] bcd_word(input int unsigned value);
        logic [31:0] w;
        int unsigned v;
        w = '0;
        v = value;
        for (int i = 0; i < DISPLAY_DIGITS; i++) begin
            w[4*i +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return w;
    endfunction

    // Apply one accepted item to the predicted state and return its result
    function automatic t_disp_result step_controller(input logic cmd, input logic [4:0] h,
                                                     input logic [5:0] m, input logic [5:0] s,
                                                     input logic [3:0] key,
                                                     input logic [31:0] tick);
        t_disp_result r;
        int unsigned  digit;
        int unsigned  shown;
        logic [31:0]  since;
        r = '0;
        digit = 10;
        since = tick - held_last_tick;
        if (!cmd) begin
            held_hours   = h;
            held_minutes = m;
            held_seconds = s;
        end else if (since >= {16'd0, held_debounce}) begin
            r.accepted = 1'b1;
            held_last_tick = tick;
            if (key[3:2] != 2'd3 && key[1:0] != 2'd3) begin
                digit = key[3:2] * 3 + key[1:0] + 1;
            end else begin
                case (key)
                    KEY_ZERO: digit = 0;
                    KEY_SET_HOURS: if (held_entry <= 23) begin
                        r.kind = SET_HOURS;
                        r.sval = held_entry[5:0];
                        held_hours = held_entry[4:0];
                        held_entry = '0;
                    end
                    KEY_SET_MINUTES: if (held_entry <= 59) begin
                        r.kind = SET_MINUTES;
                        r.sval = held_entry[5:0];
                        held_minutes = held_entry[5:0];
                        held_entry = '0;
                    end
                    KEY_SET_SECONDS: if (held_entry <= 59) begin
                        r.kind = SET_SECONDS;
                        r.sval = held_entry[5:0];
                        held_seconds = held_entry[5:0];
                        held_entry = '0;
                    end
                    KEY_PROG_ENTER: held_prog = 1'b1;
                    KEY_PROG_LEAVE: begin
                        held_prog  = 1'b0;
                        held_entry = '0;
                    end
                    default: held_entry = '0;
                endcase
            end
            // Shift the digit in, dropping the top one beyond nine digits
            if (digit < 10)
                held_entry = 30'((held_entry % 100000000) * 10 + digit);
        end
        if (held_prog)
            shown = 32'(held_entry);
        else
            shown = held_hours * 1000000 + held_minutes * 1000 + held_seconds;
        r.display = bcd_word(shown);
        r.entry   = held_entry;
        r.prog    = held_prog;
        return r;
    endfunction

    function automatic logic [3:0] digit_key(input int unsigned d);
        if (d == 0)
            return KEY_ZERO;
        return 4'(((d - 1) / 3) * 4 + (d - 1) % 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Check each result item against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_disp_result want;
        if (i_rst_n && disp_ch.valid && disp_ch.ready) begin
            if (display_due.size() == 0) begin
                report_mismatch("unexpected result", disp_ch.display_bcd, 32'd0);
            end else begin
                want = display_due.pop_front();
                compare_field("display_bcd", disp_ch.display_bcd, want.display);
                compare_field("entry_value", 32'(disp_ch.entry_value), 32'(want.entry));
                compare_field("program_mode_out", 32'(disp_ch.program_mode_out),
                              32'(want.prog));
                compare_field("set_kind", 32'(disp_ch.set_kind), 32'(want.kind));
                compare_field("set_value", 32'(disp_ch.set_value), 32'(want.sval));
                compare_field("key_accepted", 32'(disp_ch.key_accepted), 32'(want.accepted));
                if (want.accepted)
                    keys_taken++;
                if (want.kind != SET_NONE)
                    sets_made++;
            end
            stall_left = rx_idle ? $urandom_range(0, 7) : 0;
        end
    end

    // Drive result ready: long hold first, then per-item stall
    initial begin
        disp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                disp_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                disp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                disp_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one item, after a random gap when tx_idle is set, and hold it until taken
    task automatic send_item(input logic cmd, input logic [4:0] h, input logic [5:0] m,
                             input logic [5:0] s, input logic [3:0] key,
                             input logic [31:0] tick);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            key_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        key_ch.valid      <= 1'b1;
        key_ch.command    <= cmd;
        key_ch.hours_in   <= h;
        key_ch.minutes_in <= m;
        key_ch.seconds_in <= s;
        key_ch.key_code   <= key;
        key_ch.tick_ms    <= tick;
        @(posedge i_clk);
        while (!key_ch.ready)
            @(posedge i_clk);
        display_due.push_back(step_controller(cmd, h, m, s, key, tick));
        items_sent++;
    endtask

    task automatic send_key_at(input logic [3:0] key, input logic [31:0] tick);
        send_item(1'b1, 5'($urandom), 6'($urandom), 6'($urandom), key, tick);
    endtask

    task automatic send_time(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
        send_item(1'b0, h, m, s, 4'($urandom), $urandom);
    endtask

    // Advance the stamp past the debounce window, or inside it for a bounce
    task automatic press_key(input logic [3:0] key, input logic bounce);
        int unsigned delta;
        if (bounce && held_debounce != 0)
            delta = $urandom_range(0, 32'(held_debounce) - 1);
        else
            delta = 32'(held_debounce) + $urandom_range(0, 300);
        tick_now = tick_now + delta;
        send_key_at(key, tick_now);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        key_ch.valid <= 1'b0;
        while (display_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_debounce(input logic [15:0] value);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        held_debounce = value;
        debounce_writes++;
    endtask

    // One random sequence: a set, a programming session, a time sample or a stray key
    task automatic random_burst();
        int unsigned pick;
        logic [3:0]  set_key;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if ($urandom_range(0, 1))
                press_key(KEY_CLEAR, $urandom_range(0, 9) == 0);
            repeat ($urandom_range(1, 3))
                press_key(digit_key($urandom_range(0, 9)), $urandom_range(0, 9) == 0);
            case ($urandom_range(0, 2))
                0:       set_key = KEY_SET_HOURS;
                1:       set_key = KEY_SET_MINUTES;
                default: set_key = KEY_SET_SECONDS;
            endcase
            press_key(set_key, $urandom_range(0, 9) == 0);
        end else if (pick < 45) begin
            press_key(KEY_PROG_ENTER, $urandom_range(0, 9) == 0);
            repeat ($urandom_range(1, 12))
                press_key(digit_key($urandom_range(0, 9)), $urandom_range(0, 9) == 0);
            press_key($urandom_range(0, 1) ? KEY_PROG_LEAVE : KEY_CLEAR,
                      $urandom_range(0, 9) == 0);
        end else if (pick < 65) begin
            if ($urandom_range(0, 4) != 0)
                send_time(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                          6'($urandom_range(0, 59)));
            else
                send_time(5'($urandom), 6'($urandom), 6'($urandom));
        end else begin
            press_key(4'($urandom_range(0, 15)), $urandom_range(0, 4) == 0);
        end
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned first;
        first = items_sent;
        while (items_sent - first < count)
            random_burst();
    endtask

    // Every key, debounce edges from reset, entry overflow, range limits, stamp wrap
    task automatic test_directed();
        send_key_at(digit_key(1), 32'd49);
        send_key_at(KEY_PROG_ENTER, 32'd50);
        for (int d = 1; d <= 10; d++)
            send_key_at(digit_key(d % 10), 32'(50 + 50 * d));
        send_key_at(KEY_SET_HOURS, 32'd600);
        send_key_at(KEY_CLEAR, 32'd650);
        send_key_at(digit_key(2), 32'd700);
        send_key_at(digit_key(3), 32'd750);
        send_key_at(KEY_SET_HOURS, 32'd800);
        send_key_at(digit_key(6), 32'd850);
        send_key_at(digit_key(0), 32'd900);
        send_key_at(KEY_SET_MINUTES, 32'd950);
        send_key_at(KEY_SET_SECONDS, 32'd1000);
        send_key_at(KEY_CLEAR, 32'd1049);
        send_time(5'd23, 6'd59, 6'd59);
        send_time(5'd31, 6'd63, 6'd63);
        send_key_at(KEY_PROG_LEAVE, 32'hFFFF_FFF0);
        send_key_at(KEY_CLEAR, 32'h0000_0022);
        tick_now = 32'h0000_0022;
    endtask

    // Hold results off while items keep coming, then pause until all are out
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_left = 64;
        test_random_traffic(40);
        wait_results_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_left = 48;
        test_random_traffic(40);
        wait_results_drained();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        key_ch.valid      = 1'b0;
        key_ch.command    = 1'b0;
        key_ch.hours_in   = '0;
        key_ch.minutes_in = '0;
        key_ch.seconds_in = '0;
        key_ch.key_code   = '0;
        key_ch.tick_ms    = '0;
        held_entry        = '0;
        held_prog         = 1'b0;
        held_last_tick    = '0;
        held_hours        = '0;
        held_minutes      = '0;
        held_seconds      = '0;
        held_debounce     = DEBOUNCE_RESET;
        tx_idle           = 1'b1;
        rx_idle           = 1'b1;
        stall_left        = 0;
        hold_left         = 0;
        tick_now          = '0;
        items_sent        = 0;
        mismatches        = 0;
        keys_taken        = 0;
        sets_made         = 0;
        debounce_writes   = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(350);

        set_debounce(16'd0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_traffic(300);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        test_backpressure();

        set_debounce(16'hFFFF);
        test_random_traffic(300);
        set_debounce(16'd1);
        test_random_traffic(300);
        set_debounce(16'($urandom_range(2, 2000)));
        test_random_traffic(350);
        set_debounce(16'($urandom));
        test_random_traffic(200);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d items: %0d keys passed debounce, %0d time fields set,",
                 items_sent, keys_taken, sets_made);
        $display("across %0d debounce settings after the reset value.", debounce_writes);
        if (mismatches == 0 && display_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Give up if the traffic stalls
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
